// ===== hw/rtl/nmea_sentence_framer_checker_defines.svh =====
// assertion macros for the nmea sentence framer checker
// included by modules that carry concurrent checks; no other dependencies
`ifndef NMEA_SENTENCE_FRAMER_CHECKER_DEFINES_SVH
`define NMEA_SENTENCE_FRAMER_CHECKER_DEFINES_SVH
`ifndef SYNTHESIS
`define NSFC_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nsfc same-cycle check failed");
`define NSFC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nsfc next-cycle check failed");
`else
`define NSFC_ASSERT_SAME(label, clk, rst, ante, cons)
`define NSFC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hw/rtl/nsfc_pkg.sv =====
// shared types, constants and helpers for the nmea sentence framer checker
// no dependencies
package nsfc_pkg;

  localparam int MAX_SENTENCE_LEN_DEFAULT = 128;
  localparam int MIN_REPORT_LEN = 6;

  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_CR     = 8'h0D;

  typedef enum logic [1:0] {
    STATUS_VALID = 2'd0,
    STATUS_BAD   = 2'd1,
    STATUS_LONG  = 2'd2
  } status_t;

  typedef struct packed {
    logic       full;
    logic [7:0] data;
  } held_word_t;

  typedef struct packed {
    status_t     status;
    logic [6:0]  sentence_length;
    logic [7:0]  computed_sum;
    logic [7:0]  sent_sum_high_char;
    logic [7:0]  sent_sum_low_char;
    logic [15:0] good_total;
    logic [15:0] error_total;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t data;
  } track_res_t;

  function automatic logic [7:0] hex_upper(input logic [3:0] nib);
    logic [7:0] wide;
    wide = {4'b0000, nib};
    if (nib < 4'd10) begin
      hex_upper = 8'h30 + wide;
    end else begin
      hex_upper = 8'h37 + wide;
    end
  endfunction

endpackage

// ===== hw/rtl/nmea_sentence_framer_checker.sv =====
// top level of the nmea sentence framer checker
// uses nsfc_pkg, nsfc_in_reg, nsfc_tracker and nsfc_out_reg
// Takes one received word per cycle. Each closed sentence of more than six
// bytes, and each overlong sentence, gives one result word. That word reaches
// the outputs after its closing word is accepted: the closing word is held in
// the input register, then loads the result register.
// Sustained rate is one word per cycle. The only hold-off comes from the
// result register. While it is full and stalled, a held word that produces a
// result waits, and the input stalls behind it. Other words keep flowing.
module nmea_sentence_framer_checker #(
  parameter int MAX_SENTENCE_LEN = nsfc_pkg::MAX_SENTENCE_LEN_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [6:0]  sentence_length,
  output logic [7:0]  computed_sum,
  output logic [7:0]  sent_sum_high_char,
  output logic [7:0]  sent_sum_low_char,
  output logic [15:0] good_total,
  output logic [15:0] error_total
);

  nsfc_pkg::held_word_t held;
  nsfc_pkg::track_res_t res;
  nsfc_pkg::result_t    out_data;
  logic                 room;
  logic                 advance;

  assign advance = held.full && (!res.valid || room);

  nsfc_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .rx_byte  (rx_byte),
    .advance  (advance),
    .held     (held)
  );

  nsfc_tracker #(
    .MaxLen (MAX_SENTENCE_LEN)
  ) u_tracker (
    .clk     (clk),
    .rst     (rst),
    .held    (held),
    .advance (advance),
    .res     (res)
  );

  nsfc_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .res       (res),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign status             = out_data.status;
  assign sentence_length    = out_data.sentence_length;
  assign computed_sum       = out_data.computed_sum;
  assign sent_sum_high_char = out_data.sent_sum_high_char;
  assign sent_sum_low_char  = out_data.sent_sum_low_char;
  assign good_total         = out_data.good_total;
  assign error_total        = out_data.error_total;

endmodule

// ===== hw/rtl/nsfc_in_reg.sv =====
// input register for received words
// uses nsfc_pkg
module nsfc_in_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          rx_byte,
  input  logic                advance,
  output nsfc_pkg::held_word_t held
);

  logic       full;
  logic [7:0] data;

  assign in_stall = full && !advance;
  assign held = '{full: full, data: data};

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (!in_stall) begin
      full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      data <= rx_byte;
    end
  end

endmodule

// ===== hw/rtl/nsfc_tracker.sv =====
// sentence state, checksum tracking and result decision for one held word
// uses nsfc_pkg and the assertion macros header
`include "nmea_sentence_framer_checker_defines.svh"
module nsfc_tracker #(
  parameter int MaxLen = nsfc_pkg::MAX_SENTENCE_LEN_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  nsfc_pkg::held_word_t held,
  input  logic                 advance,
  output nsfc_pkg::track_res_t res
);

  localparam int LenW = $clog2(MaxLen);
  localparam logic [LenW-1:0] LenLimit = LenW'(MaxLen - 1);
  localparam logic [LenW-1:0] LenMin = LenW'(nsfc_pkg::MIN_REPORT_LEN);

  logic [LenW-1:0] open_length, open_length_next;
  logic [7:0]      running_xor, running_xor_next;
  logic            star_seen, star_seen_next;
  logic [1:0]      digits_taken, digits_taken_next;
  logic [7:0]      digit_high, digit_high_next;
  logic [7:0]      digit_low, digit_low_next;
  logic [15:0]     good_count, good_count_next;
  logic [15:0]     error_count, error_count_next;
  logic            sum_ok;
  logic            is_eol;

  assign is_eol = held.data inside {nsfc_pkg::CHAR_CR, nsfc_pkg::CHAR_LF};
  assign sum_ok = star_seen && (digits_taken == 2'd2) &&
                  (digit_high == nsfc_pkg::hex_upper(running_xor[7:4])) &&
                  (digit_low == nsfc_pkg::hex_upper(running_xor[3:0]));

  always_comb begin
    open_length_next  = open_length;
    running_xor_next  = running_xor;
    star_seen_next    = star_seen;
    digits_taken_next = digits_taken;
    digit_high_next   = digit_high;
    digit_low_next    = digit_low;
    good_count_next   = good_count;
    error_count_next  = error_count;
    res.valid         = 1'b0;
    res.data.status   = nsfc_pkg::STATUS_BAD;

    if (held.full) begin
      if (held.data == nsfc_pkg::CHAR_DOLLAR) begin
        open_length_next  = LenW'(1);
        running_xor_next  = 8'h00;
        star_seen_next    = 1'b0;
        digits_taken_next = 2'd0;
        digit_high_next   = 8'h00;
        digit_low_next    = 8'h00;
      end else if (open_length != '0) begin
        if (is_eol || open_length == LenLimit) begin
          // close the sentence
          open_length_next  = '0;
          running_xor_next  = 8'h00;
          star_seen_next    = 1'b0;
          digits_taken_next = 2'd0;
          digit_high_next   = 8'h00;
          digit_low_next    = 8'h00;
          if (!is_eol) begin
            res.valid        = 1'b1;
            res.data.status  = nsfc_pkg::STATUS_LONG;
            error_count_next = error_count + 16'd1;
          end else if (open_length > LenMin) begin
            res.valid = 1'b1;
            if (sum_ok) begin
              res.data.status = nsfc_pkg::STATUS_VALID;
              good_count_next = good_count + 16'd1;
            end else begin
              error_count_next = error_count + 16'd1;
            end
          end
        end else begin
          open_length_next = open_length + LenW'(1);
          if (!star_seen) begin
            if (held.data == nsfc_pkg::CHAR_STAR) begin
              star_seen_next = 1'b1;
            end else begin
              running_xor_next = running_xor ^ held.data;
            end
          end else if (digits_taken == 2'd0) begin
            digit_high_next   = held.data;
            digits_taken_next = 2'd1;
          end else if (digits_taken == 2'd1) begin
            digit_low_next    = held.data;
            digits_taken_next = 2'd2;
          end
        end
      end
    end

    res.data.sentence_length    = 7'(open_length);
    res.data.computed_sum       = running_xor;
    res.data.sent_sum_high_char = digit_high;
    res.data.sent_sum_low_char  = digit_low;
    res.data.good_total         = good_count_next;
    res.data.error_total        = error_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open_length  <= '0;
      running_xor  <= 8'h00;
      star_seen    <= 1'b0;
      digits_taken <= 2'd0;
      digit_high   <= 8'h00;
      digit_low    <= 8'h00;
      good_count   <= 16'd0;
      error_count  <= 16'd0;
    end else if (advance) begin
      open_length  <= open_length_next;
      running_xor  <= running_xor_next;
      star_seen    <= star_seen_next;
      digits_taken <= digits_taken_next;
      digit_high   <= digit_high_next;
      digit_low    <= digit_low_next;
      good_count   <= good_count_next;
      error_count  <= error_count_next;
    end
  end

  `NSFC_ASSERT_SAME(a_len_in_range, clk, rst, 1'b1, open_length <= LenLimit)
  `NSFC_ASSERT_SAME(a_digits_need_star, clk, rst, digits_taken != 2'd0, star_seen)
  `NSFC_ASSERT_SAME(a_long_at_limit, clk, rst, res.valid && res.data.status == nsfc_pkg::STATUS_LONG, open_length == LenLimit)
  `NSFC_ASSERT_NEXT(a_dollar_opens, clk, rst, advance && held.full && held.data == nsfc_pkg::CHAR_DOLLAR, open_length == LenW'(1) && !star_seen && running_xor == 8'h00)

endmodule

// ===== hw/rtl/nsfc_out_reg.sv =====
// result register that holds a result word until the consumer takes it
// uses nsfc_pkg
module nsfc_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  nsfc_pkg::track_res_t res,
  output logic                 room,
  output logic                 out_valid,
  input  logic                 out_stall,
  output nsfc_pkg::result_t    out_data
);

  assign room = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res.valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      out_data <= res.data;
    end
  end

endmodule
